FILE: sv/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, constants and helpers for the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

    localparam int POWERUP_TICKS_DEF = 50;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_CMD    = 3'd1;
    localparam logic [2:0] REQ_DATA   = 3'd2;
    localparam logic [2:0] REQ_CURSOR = 3'd3;
    localparam logic [2:0] REQ_INIT   = 3'd4;

    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [6:0] ROW1_BASE     = 7'h40;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;

    localparam logic [3:0] STEP_BYTE     = 4'd0;
    localparam logic [3:0] STEP_NIB_LAST = 4'd4;
    localparam logic [3:0] STEP_CMD_FST  = 4'd5;
    localparam logic [3:0] STEP_CMD_LST  = 4'd8;

    typedef enum logic [1:0] {
        K_TICK = 2'd0,
        K_BYTE = 2'd1,
        K_INIT = 2'd2,
        K_NOP  = 2'd3
    } kind_t;

    // classified request
    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_val;
        logic       rs;
    } cmd_t;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_POWERUP = 8'b0000_0010,
        PH_NIB_HI  = 8'b0000_0100,
        PH_NIB_LO  = 8'b0000_1000,
        PH_UP_HI   = 8'b0001_0000,
        PH_UP_LO   = 8'b0010_0000,
        PH_DN_HI   = 8'b0100_0000,
        PH_DN_LO   = 8'b1000_0000
    } phase_t;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CMD_FUNC_SET;
            2'd1:    c = CMD_DISP_ON;
            2'd2:    c = CMD_ENTRY;
            default: c = CMD_CLEAR;
        endcase
        return c;
    endfunction

    // low-phase length after each wake-up nibble
    function automatic logic [5:0] nib_after(input logic [1:0] idx);
        logic [5:0] w;
        case (idx)
            2'd0:    w = 6'd6;
            2'd1:    w = 6'd6;
            default: w = 6'd2;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front
// Request decode: classifies each item and builds the byte to send.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_front import clcd_pkg::*; (
    input  wire logic [2:0] req_type,
    input  wire logic [7:0] byte_value,
    input  wire logic       row,
    input  wire logic [5:0] col,
    output cmd_t            cmd
);

    logic [6:0] addr;

    always_comb
    begin
        addr = row ? (ROW1_BASE + {1'b0, col}) : {1'b0, col};
        cmd  = '{kind: K_NOP, byte_val: byte_value, rs: 1'b0};
        case (req_type)
            REQ_TICK:   cmd.kind = K_TICK;
            REQ_CMD:    cmd.kind = K_BYTE;
            REQ_DATA:
            begin
                cmd.kind = K_BYTE;
                cmd.rs   = 1'b1;
            end
            REQ_CURSOR:
            begin
                cmd.kind     = K_BYTE;
                cmd.byte_val = {1'b1, addr};
            end
            REQ_INIT:   cmd.kind = K_INIT;
            default:    cmd.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/clcd_fifo.sv
// ----------------------------------------------------------------------------
// clcd_fifo
// Short queue of classified requests between decode and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_fifo import clcd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;

    assign wr_ready = (cnt_reg != FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next = push ? ((wptr_reg == LAST) ? '0 : wptr_reg + 1'b1) : wptr_reg;
        rptr_next = pop  ? ((rptr_reg == LAST) ? '0 : rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: sv/clcd_seq.sv
// ----------------------------------------------------------------------------
// clcd_seq
// Pin sequencer: one request/tick per cycle unless out stalls; registers pins.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq import clcd_pkg::*; #(
    parameter int POWERUP_TICKS = POWERUP_TICKS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire cmd_t       cmd,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            rs_pin,
    output logic            enable_pin,
    output logic [3:0]      data_pins,
    output logic            busy_res,
    output logic            rejected
);

    localparam logic [5:0] PU_RAW  = 6'(POWERUP_TICKS % 64);
    localparam logic [5:0] PU_WAIT = (PU_RAW == 6'd0) ? 6'd1 : PU_RAW;

    phase_t     phase_reg, phase_next;
    logic [5:0] wait_reg, wait_next;
    logic [7:0] held_reg, held_next;
    logic [3:0] step_reg, step_next;
    logic       rs_reg, rs_next;
    logic       en_reg, en_next;
    logic [3:0] data_reg, data_next;
    logic       oval_reg, oval_next;
    logic       rej_reg, rej_next;
    logic       busy_reg;
    logic       take;
    logic       busy;
    logic [3:0] step_inc;
    logic [3:0] step_dec;

    assign cmd_ready  = !oval_reg || out_ready;
    assign take       = cmd_valid && cmd_ready;
    assign busy       = (phase_reg != PH_IDLE);
    assign out_valid  = oval_reg;
    assign rs_pin     = rs_reg;
    assign enable_pin = en_reg;
    assign data_pins  = data_reg;
    assign busy_res   = busy_reg;
    assign rejected   = rej_reg;

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        held_next  = held_reg;
        step_next  = step_reg;
        rs_next    = rs_reg;
        en_next    = en_reg;
        data_next  = data_reg;
        rej_next   = 1'b0;
        step_inc   = step_reg + 4'd1;
        step_dec   = step_reg - 4'd1;
        oval_next  = take ? 1'b1 : (out_ready ? 1'b0 : oval_reg);

        if (take)
        begin
            case (cmd.kind)
                K_TICK:
                begin
                    if (busy && (wait_reg <= 6'd1))
                    begin
                        case (phase_reg)
                            PH_POWERUP:
                            begin
                                step_next  = 4'd1;
                                data_next  = NIB_WAKE;
                                phase_next = PH_NIB_HI;
                                en_next    = 1'b1;
                                wait_next  = 6'd1;
                            end
                            PH_NIB_HI:
                            begin
                                phase_next = PH_NIB_LO;
                                en_next    = 1'b0;
                                wait_next  = nib_after(step_dec[1:0]);
                            end
                            PH_NIB_LO:
                            begin
                                if ((step_inc >= 4'd1) && (step_inc <= STEP_NIB_LAST))
                                begin
                                    step_next  = step_inc;
                                    data_next  = (step_inc == STEP_NIB_LAST) ?
                                                 NIB_4BIT : NIB_WAKE;
                                    phase_next = PH_NIB_HI;
                                end
                                else
                                begin
                                    step_next  = STEP_CMD_FST;
                                    held_next  = CMD_FUNC_SET;
                                    rs_next    = 1'b0;
                                    data_next  = CMD_FUNC_SET[7:4];
                                    phase_next = PH_UP_HI;
                                end
                                en_next   = 1'b1;
                                wait_next = 6'd1;
                            end
                            PH_UP_HI:
                            begin
                                phase_next = PH_UP_LO;
                                en_next    = 1'b0;
                                wait_next  = 6'd1;
                            end
                            PH_UP_LO:
                            begin
                                data_next  = held_reg[3:0];
                                phase_next = PH_DN_HI;
                                en_next    = 1'b1;
                                wait_next  = 6'd1;
                            end
                            PH_DN_HI:
                            begin
                                phase_next = PH_DN_LO;
                                en_next    = 1'b0;
                                wait_next  = (step_reg == STEP_CMD_LST) ? 6'd6 : 6'd4;
                            end
                            PH_DN_LO:
                            begin
                                if ((step_reg >= STEP_CMD_FST) && (step_reg < STEP_CMD_LST))
                                begin
                                    step_next  = step_inc;
                                    held_next  = init_cmd(step_inc[1:0] - 2'd1);
                                    rs_next    = 1'b0;
                                    data_next  = held_next[7:4];
                                    phase_next = PH_UP_HI;
                                    en_next    = 1'b1;
                                    wait_next  = 6'd1;
                                end
                                else
                                begin
                                    step_next  = STEP_BYTE;
                                    phase_next = PH_IDLE;
                                    wait_next  = 6'd0;
                                    en_next    = 1'b0;
                                end
                            end
                            default:
                            begin
                                step_next  = STEP_BYTE;
                                phase_next = PH_IDLE;
                                wait_next  = 6'd0;
                                en_next    = 1'b0;
                            end
                        endcase
                    end
                    else if (busy)
                        wait_next = wait_reg - 6'd1;
                end
                K_BYTE:
                begin
                    if (busy)
                        rej_next = 1'b1;
                    else
                    begin
                        step_next  = STEP_BYTE;
                        held_next  = cmd.byte_val;
                        rs_next    = cmd.rs;
                        data_next  = cmd.byte_val[7:4];
                        phase_next = PH_UP_HI;
                        en_next    = 1'b1;
                        wait_next  = 6'd1;
                    end
                end
                K_INIT:
                begin
                    if (busy)
                        rej_next = 1'b1;
                    else
                    begin
                        step_next  = STEP_BYTE;
                        phase_next = PH_POWERUP;
                        wait_next  = PU_WAIT;
                    end
                end
                default:
                begin
                    rej_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            held_reg  <= '0;
            step_reg  <= '0;
            rs_reg    <= 1'b0;
            en_reg    <= 1'b0;
            data_reg  <= '0;
            oval_reg  <= 1'b0;
            rej_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            held_reg  <= held_next;
            step_reg  <= step_next;
            rs_reg    <= rs_next;
            en_reg    <= en_next;
            data_reg  <= data_next;
            oval_reg  <= oval_next;
            if (take)
            begin
                rej_reg  <= rej_next;
                busy_reg <= (phase_next != PH_IDLE);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/char_lcd_4bit_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface
// Character LCD driver on a 4-bit bus (RS, E, D4..D7), timed by tick requests.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid/in_ready, req_type, byte_value, | in
//           | row, col                                 |
//   out     | out_valid/out_ready, rs_pin, enable_pin, | out
//           | data_pins, busy_res, rejected            |
//
// One request per cycle sustained while out_ready is high; a request leaves
// the queue and its result is registered at the edge after acceptance.
// The sequencer retires one queued request per cycle whenever the output
// register is free or being taken; the queue holds QUEUE_DEPTH requests.
// Reset clears the queue, the sequencer (idle, pins low) and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_interface import clcd_pkg::*; #(
    parameter int POWERUP_TICKS = POWERUP_TICKS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] req_type,
    input  wire logic [7:0] byte_value,
    input  wire logic       row,
    input  wire logic [5:0] col,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            rs_pin,
    output logic            enable_pin,
    output logic [3:0]      data_pins,
    output logic            busy_res,
    output logic            rejected
);

    cmd_t dec_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    clcd_front u_front (
        .req_type   (req_type),
        .byte_value (byte_value),
        .row        (row),
        .col        (col),
        .cmd        (dec_cmd)
    );

    clcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (dec_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    clcd_seq #(
        .POWERUP_TICKS (POWERUP_TICKS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd        (q_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rs_pin     (rs_pin),
        .enable_pin (enable_pin),
        .data_pins  (data_pins),
        .busy_res   (busy_res),
        .rejected   (rejected)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: character LCD 4-bit interface testbench
// Drives tick, command, data, set-cursor and init requests through the
// request channel and checks each pin/status result against an in-bench
// model of the bus sequencer or a fixed row value. A short directed table
// comes first, then random traffic, mostly ticks while the model is busy.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clcd_pkg::*;

    localparam int POWERUP = POWERUP_TICKS_DEF;
    localparam int ITEM_TARGET = 550;
    localparam logic [2:0] REQ_NOP_LO = 3'd5;
    localparam logic [2:0] REQ_NOP_HI = 3'd7;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
    } lcd_req_t;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] data;
        logic       busy;
        logic       rej;
    } lcd_pins_t;

    typedef struct packed {
        lcd_req_t  req;
        logic [5:0] reps;
        logic       typed;
        lcd_pins_t  want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] req_type;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] col;
    logic       out_valid;
    logic       out_ready;
    logic       rs_pin;
    logic       enable_pin;
    logic [3:0] data_pins;
    logic       busy_res;
    logic       rejected;

    lcd_pins_t pins_due[$];
    int        n_sent;
    int        errors;

    // sequencer model state
    phase_t     m_phase;
    logic [5:0] m_wait;
    logic [7:0] m_byte;
    logic [3:0] m_step;
    logic       m_rs;
    logic       m_en;
    logic [3:0] m_data;

    dir_row_t dir_table [10] = '{
        '{'{REQ_TICK,   8'h00, 1'b0, 6'd0},  6'd1, 1'b1, '0},
        '{'{REQ_NOP_HI, 8'h00, 1'b0, 6'd0},  6'd1, 1'b1, '0},
        '{'{REQ_DATA,   8'hFF, 1'b0, 6'd0},  6'd1, 1'b1, '{1'b1, 1'b1, 4'hF, 1'b1, 1'b0}},
        '{'{REQ_CMD,    8'h00, 1'b0, 6'd0},  6'd1, 1'b1, '{1'b1, 1'b1, 4'hF, 1'b1, 1'b1}},
        '{'{REQ_INIT,   8'h00, 1'b0, 6'd0},  6'd1, 1'b1, '{1'b1, 1'b1, 4'hF, 1'b1, 1'b1}},
        '{'{REQ_TICK,   8'h00, 1'b0, 6'd0},  6'd7, 1'b0, '0},
        '{'{REQ_CURSOR, 8'h00, 1'b1, 6'd63}, 6'd1, 1'b0, '0},
        '{'{REQ_NOP_LO, 8'hFF, 1'b1, 6'd63}, 6'd1, 1'b0, '0},
        '{'{REQ_TICK,   8'hFF, 1'b1, 6'd63}, 6'd7, 1'b0, '0},
        '{'{REQ_INIT,   8'h00, 1'b0, 6'd0},  6'd1, 1'b0, '0}
    };

    char_lcd_4bit_interface #(
        .POWERUP_TICKS (POWERUP)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .byte_value (byte_value),
        .row        (row),
        .col        (col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rs_pin     (rs_pin),
        .enable_pin (enable_pin),
        .data_pins  (data_pins),
        .busy_res   (busy_res),
        .rejected   (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------- sequencer model ----------------

    function automatic void seq_goto(input phase_t ph, input logic en, input logic [5:0] ticks);
        m_phase = ph;
        m_en    = en;
        m_wait  = (ticks == 6'd0) ? 6'd1 : ticks;
    endfunction

    function automatic void seq_start_byte(input logic [7:0] b, input logic rs);
        m_byte = b;
        m_rs   = rs;
        m_data = b[7:4];
        seq_goto(PH_UP_HI, 1'b1, 6'd1);
    endfunction

    function automatic void seq_wake_nibble();
        m_data = (m_step == STEP_NIB_LAST) ? NIB_4BIT : NIB_WAKE;
        seq_goto(PH_NIB_HI, 1'b1, 6'd1);
    endfunction

    function automatic logic [7:0] seq_init_byte(input logic [3:0] step);
        logic [7:0] c;
        case (step - STEP_CMD_FST)
            4'd0:    c = CMD_FUNC_SET;
            4'd1:    c = CMD_DISP_ON;
            4'd2:    c = CMD_ENTRY;
            default: c = CMD_CLEAR;
        endcase
        return c;
    endfunction

    function automatic void seq_go_idle();
        m_step  = STEP_BYTE;
        m_phase = PH_IDLE;
        m_wait  = 6'd0;
        m_en    = 1'b0;
    endfunction

    function automatic void seq_advance();
        logic [3:0] nib_idx;
        case (m_phase)
            PH_POWERUP:
            begin
                m_step = 4'd1;
                seq_wake_nibble();
            end
            PH_NIB_HI:
            begin
                nib_idx = m_step - 4'd1;
                seq_goto(PH_NIB_LO, 1'b0, (nib_idx[1:0] < 2'd2) ? 6'd6 : 6'd2);
            end
            PH_NIB_LO:
            begin
                m_step = m_step + 4'd1;
                if (m_step >= 4'd1 && m_step <= STEP_NIB_LAST)
                    seq_wake_nibble();
                else
                begin
                    m_step = STEP_CMD_FST;
                    seq_start_byte(CMD_FUNC_SET, 1'b0);
                end
            end
            PH_UP_HI:
                seq_goto(PH_UP_LO, 1'b0, 6'd1);
            PH_UP_LO:
            begin
                m_data = m_byte[3:0];
                seq_goto(PH_DN_HI, 1'b1, 6'd1);
            end
            PH_DN_HI:
                seq_goto(PH_DN_LO, 1'b0, (m_step == STEP_CMD_LST) ? 6'd6 : 6'd4);
            PH_DN_LO:
            begin
                if (m_step >= STEP_CMD_FST && m_step < STEP_CMD_LST)
                begin
                    m_step = m_step + 4'd1;
                    seq_start_byte(seq_init_byte(m_step), 1'b0);
                end
                else
                    seq_go_idle();
            end
            default:
                seq_go_idle();
        endcase
    endfunction

    function automatic lcd_pins_t seq_apply(input lcd_req_t r);
        lcd_pins_t  p;
        logic       was_busy;
        logic [7:0] addr;
        p.rej    = 1'b0;
        was_busy = (m_phase != PH_IDLE);
        if (r.kind == REQ_TICK)
        begin
            if (was_busy)
            begin
                if (m_wait > 6'd0)
                    m_wait = m_wait - 6'd1;
                if (m_wait == 6'd0)
                    seq_advance();
            end
        end
        else if (r.kind <= REQ_INIT)
        begin
            if (was_busy)
                p.rej = 1'b1;
            else
            begin
                m_step = STEP_BYTE;
                case (r.kind)
                    REQ_CMD:  seq_start_byte(r.value, 1'b0);
                    REQ_DATA: seq_start_byte(r.value, 1'b1);
                    REQ_CURSOR:
                    begin
                        addr = r.row ? ({1'b0, ROW1_BASE} + {2'b00, r.col}) : {2'b00, r.col};
                        seq_start_byte(CMD_SET_ADDR | addr, 1'b0);
                    end
                    default:  seq_goto(PH_POWERUP, m_en, 6'(POWERUP));
                endcase
            end
        end
        p.rs   = m_rs;
        p.en   = m_en;
        p.data = m_data;
        p.busy = (m_phase != PH_IDLE);
        return p;
    endfunction

    // ---------------- request side ----------------

    function automatic bit quiet_stretch();
        return n_sent >= 150 && n_sent < 250;
    endfunction

    task automatic idle_gap();
        if (!quiet_stretch() && $urandom_range(99, 0) < 3)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
    endtask

    task automatic send_request(input lcd_req_t r, input logic typed, input lcd_pins_t want);
        lcd_pins_t p;
        in_valid   <= 1'b1;
        req_type   <= r.kind;
        byte_value <= r.value;
        row        <= r.row;
        col        <= r.col;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = seq_apply(r);
        pins_due.push_back(typed ? want : p);
        n_sent++;
    endtask

    initial
    begin
        lcd_req_t r;
        int       n_items;
        int       pick;
        bit       paused;
        n_items    = 0;
        paused     = 0;
        n_sent     = 0;
        errors     = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_TICK;
        byte_value <= 8'h00;
        row        <= 1'b0;
        col        <= 6'd0;
        m_phase = PH_IDLE;
        m_wait  = 6'd0;
        m_byte  = 8'h00;
        m_step  = STEP_BYTE;
        m_rs    = 1'b0;
        m_en    = 1'b0;
        m_data  = 4'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            for (int k = 0; k < dir_table[i].reps; k++)
            begin
                idle_gap();
                send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].want);
                if (dir_table[i].req.kind <= REQ_INIT)
                    n_items++;
            end
        end

        while (n_items < ITEM_TARGET)
        begin
            if (!paused && n_sent >= 450)
            begin
                paused = 1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pins_due.size() != 0)
                    @(posedge clk);
            end
            r.value = 8'($urandom_range(255, 0));
            r.row   = 1'($urandom_range(1, 0));
            r.col   = 6'($urandom_range(63, 0));
            pick    = $urandom_range(99, 0);
            if (m_phase == PH_IDLE)
            begin
                if (pick < 4)
                    r.kind = REQ_INIT;
                else if (pick < 30)
                    r.kind = REQ_CMD;
                else if (pick < 56)
                    r.kind = REQ_DATA;
                else if (pick < 82)
                    r.kind = REQ_CURSOR;
                else if (pick < 93)
                    r.kind = REQ_TICK;
                else
                    r.kind = 3'($urandom_range(REQ_NOP_HI, REQ_NOP_LO));
            end
            else
            begin
                if (pick < 85)
                    r.kind = REQ_TICK;
                else if (pick < 95)
                    r.kind = 3'($urandom_range(REQ_INIT, REQ_CMD));
                else
                    r.kind = 3'($urandom_range(REQ_NOP_HI, REQ_NOP_LO));
            end
            idle_gap();
            send_request(r, 1'b0, '0);
            if (r.kind <= REQ_INIT)
                n_items++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pins_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ---------------- result side ----------------

    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && n_sent >= 300)
            begin
                held      = 1;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (quiet_stretch())
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99, 0) >= 9);
        end
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    initial
    begin
        lcd_pins_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pins_due.size() == 0)
                    note_mismatch("result with no request", 1, 0);
                else
                begin
                    want = pins_due.pop_front();
                    if (rs_pin !== want.rs)
                        note_mismatch("rs_pin", rs_pin, want.rs);
                    if (enable_pin !== want.en)
                        note_mismatch("enable_pin", enable_pin, want.en);
                    if (data_pins !== want.data)
                        note_mismatch("data_pins", data_pins, want.data);
                    if (busy_res !== want.busy)
                        note_mismatch("busy_res", busy_res, want.busy);
                    if (rejected !== want.rej)
                        note_mismatch("rejected", rejected, want.rej);
                end
            end
        end
    end

endmodule
